>>> hdl/lmc5_pkg.sv
// shared types, constants and coefficient helpers for the laws 5x5 mask filter
package lmc5_pkg;

   localparam int DEF_MAX_WIDTH = 128;
   localparam int MAX_HEIGHT    = 4096;
   localparam int ROW_BITS      = 12;
   localparam int HEIGHT_BITS   = 13;
   localparam int RING_ROWS     = 8;
   localparam int LANE_BITS     = 3;
   localparam int FIFO_DEPTH    = 8;
   localparam int ADDR_BITS     = 4;

   // register indexes on the csr port
   localparam logic [1:0] REG_FILTER_SELECT = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;

   localparam logic [4:0]             RST_FILTER_SELECT = 5'd0;
   localparam logic [7:0]             RST_IMAGE_WIDTH   = 8'd128;
   localparam logic [HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT  = 13'd128;

   // word kinds on the request channel
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam logic [4:0] LAST_MASK = 5'd24;

   // L5, E5, S5, W5, R5
   localparam logic signed [3:0] LAWS_VEC [5][5] = '{
      '{ 4'sd1,  4'sd4, 4'sd6,  4'sd4,  4'sd1},
      '{-4'sd1, -4'sd2, 4'sd0,  4'sd2,  4'sd1},
      '{-4'sd1,  4'sd0, 4'sd2,  4'sd0, -4'sd1},
      '{-4'sd1,  4'sd2, 4'sd0, -4'sd2,  4'sd1},
      '{ 4'sd1, -4'sd4, 4'sd6, -4'sd4,  4'sd1}
   };

   typedef struct packed {
      logic       func;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] filtered_value;
      logic       last_of_image;
   } rsp_type;

   // what the window stage does with the column read for a word
   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_START,
      STEP_SHIFT,
      STEP_CENTER,
      STEP_EDGE,
      STEP_PREFETCH
   } step_type;

   typedef struct packed {
      step_type             step;
      logic                 pf_sel;
      logic                 last;
      logic                 fwd_hit;
      logic [LANE_BITS-1:0] fwd_lane;
   } s1_ctrl_type;

   function automatic logic [4:0] mask_sat(input logic [4:0] sel);
      return (sel > LAST_MASK) ? LAST_MASK : sel;
   endfunction

   // row vector index, mask number divided by five
   function automatic logic [2:0] mask_row_vec(input logic [4:0] sel);
      logic [4:0] s;
      s = mask_sat(sel);
      if (s >= 5'd20) begin
         return 3'd4;
      end else if (s >= 5'd15) begin
         return 3'd3;
      end else if (s >= 5'd10) begin
         return 3'd2;
      end else if (s >= 5'd5) begin
         return 3'd1;
      end
      return 3'd0;
   endfunction

   // column vector index, mask number modulo five
   function automatic logic [2:0] mask_col_vec(input logic [4:0] sel);
      logic [4:0] s;
      logic [4:0] base;
      s    = mask_sat(sel);
      base = 5'(5 * int'(mask_row_vec(sel)));
      return 3'(s - base);
   endfunction

endpackage

>>> hdl/laws_mask_convolution_5x5.sv
// laws 5x5 texture mask filter: line store, window, separable sum and result queue
// rsp_valid rises once the result of an accepted word is written into the result queue
// throughput: one word per cycle sustained, set by the single read port of the line
//   store, which is used at most once per word; req_ready drops only while eight
//   results are in flight or queued
// reset: synchronous; clears counters, pipeline and queue, filter_select 0, width and
//   height 128; the line store is not cleared and needs no clearing pass
module laws_mask_convolution_5x5
   import lmc5_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int LW         = $clog2(2 * MAX_WIDTH + 3);
   localparam int PB         = $clog2(FIFO_DEPTH);
   localparam int CRED_BITS  = $clog2(FIFO_DEPTH + 1);

   // configuration registers
   logic [4:0]             filter_ff, filter_in;
   logic [7:0]             width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;

   // stream position
   logic [CW-1:0]       in_col_ff, in_col_in;
   logic [ROW_BITS-1:0] in_row_ff, in_row_in;
   logic [CW-1:0]       out_col_ff, out_col_in;
   logic [ROW_BITS-1:0] out_row_ff, out_row_in;
   logic [LW-1:0]       lead_ff, lead_in;
   logic                in_done_ff, in_done_in;

   // credit for results in flight or queued
   logic [CRED_BITS-1:0] credit_ff, credit_in;

   logic [WW-1:0]          eff_w;
   logic [HEIGHT_BITS-1:0] eff_h;
   logic [CW-1:0]          w_m1, w_m2;
   logic [ROW_BITS-1:0]    h_m1;
   logic [LW-1:0]          lead_tgt;

   logic cfg_we;
   logic acc, is_pix, mem_we, emit, in_last, out_last, row0_pf;

   // stage 0 read request
   step_type             step_s0;
   logic [CW-1:0]        rd_col;
   logic [ROW_BITS:0]    tgt_row;
   logic                 pf_sel_s0;
   logic [LANE_BITS-1:0] lane_s0 [5];
   logic [LANE_BITS-1:0] wr_lane;

   // line store: one word per column, one byte lane per ring row
   logic [RING_ROWS-1:0][7:0] line_store_ff [MAX_WIDTH];
   logic [RING_ROWS-1:0][7:0] rd_data_ff;

   // stage 1
   s1_ctrl_type          s1_ctrl_ff, s1_ctrl_in;
   logic [LANE_BITS-1:0] s1_lane_ff [5];
   logic [7:0]           fwd_data_ff;
   logic [7:0]           merged [RING_ROWS];
   logic [7:0]           col_s1 [5];

   // window and the two prefetched columns opening a row
   logic [7:0] win_ff [5][5];
   logic [7:0] pre_ff [2][5];

   // stage 2 and 3
   logic                s2_valid_ff, s2_valid_in, s2_last_ff;
   logic [2:0]          vec_row, vec_col;
   logic signed [13:0]  row_sum [5];
   logic signed [13:0]  rs_ff [5];
   logic                s3_valid_ff, s3_last_ff;
   logic signed [17:0]  total;
   logic [7:0]          clamped;

   // result queue
   rsp_type       fifo_ff [FIFO_DEPTH];
   logic [PB:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PB:0]   fifo_count;
   logic          pop;

   // ---------------------------------------------------------------- csr port
   assign pready = 1'b1;
   assign cfg_we = psel & penable & pwrite & pready;

   always_comb begin
      case (paddr[ADDR_BITS-1:2])
         REG_FILTER_SELECT: prdata = {27'd0, filter_ff};
         REG_IMAGE_WIDTH:   prdata = {24'd0, width_ff};
         REG_IMAGE_HEIGHT:  prdata = {19'd0, height_ff};
         default:           prdata = '0;
      endcase
   end

   // sizes in use, clamped to the supported range
   always_comb begin
      if (int'(width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else if (width_ff < 8'd3) begin
         eff_w = WW'(3);
      end else begin
         eff_w = WW'(width_ff);
      end
      if (height_ff > HEIGHT_BITS'(MAX_HEIGHT)) begin
         eff_h = HEIGHT_BITS'(MAX_HEIGHT);
      end else if (height_ff < HEIGHT_BITS'(3)) begin
         eff_h = HEIGHT_BITS'(3);
      end else begin
         eff_h = height_ff;
      end
   end

   assign w_m1     = CW'(eff_w - WW'(1));
   assign w_m2     = CW'(eff_w - WW'(2));
   assign h_m1     = ROW_BITS'(eff_h - HEIGHT_BITS'(1));
   // a result is due once the input is two rows and three pixels ahead
   assign lead_tgt = LW'(2 * int'(eff_w) + 2);

   // ---------------------------------------------------------------- stage 0
   assign req_ready = credit_ff < CRED_BITS'(FIFO_DEPTH);
   assign acc       = req_valid & req_ready;
   assign is_pix    = req_data.func == FUNC_PIXEL;
   // once the whole image is in, pixels are dropped and every word flushes one result
   assign mem_we    = acc & ~in_done_ff & is_pix;
   assign emit      = acc & (in_done_ff | (is_pix & (lead_ff == lead_tgt)));
   assign in_last   = (in_row_ff == h_m1) && (in_col_ff == w_m1);
   assign out_last  = (out_row_ff == h_m1) && (out_col_ff == w_m1);
   // the opening columns of the first row are fetched while row two streams in
   assign row0_pf   = mem_we && (in_row_ff == ROW_BITS'(2)) && (in_col_ff < CW'(2));
   assign wr_lane   = in_row_ff[LANE_BITS-1:0];

   // choose what column to read and for which output row
   always_comb begin
      step_s0   = STEP_NONE;
      rd_col    = out_col_ff + CW'(2);
      tgt_row   = {1'b0, out_row_ff};
      pf_sel_s0 = 1'b0;
      if (emit) begin
         if (out_col_ff == '0) begin
            step_s0 = STEP_START;
         end else if (out_col_ff == w_m1) begin
            // right edge mirrors a column already held, so the port fetches
            // the second column of the next row
            step_s0   = STEP_EDGE;
            rd_col    = CW'(1);
            tgt_row   = {1'b0, out_row_ff} + (ROW_BITS + 1)'(1);
            pf_sel_s0 = 1'b1;
         end else if (out_col_ff == w_m2) begin
            step_s0 = STEP_CENTER;
            rd_col  = '0;
            tgt_row = {1'b0, out_row_ff} + (ROW_BITS + 1)'(1);
         end else begin
            step_s0 = STEP_SHIFT;
         end
      end else if (row0_pf) begin
         step_s0   = STEP_PREFETCH;
         rd_col    = in_col_ff;
         tgt_row   = '0;
         pf_sel_s0 = in_col_ff[0];
      end
   end

   // ring lanes of the five window rows, mirrored at top and bottom
   always_comb begin
      logic signed [14:0] rx;
      logic signed [14:0] hs;
      hs = $signed({2'b00, eff_h});
      for (int d = 0; d < 5; d++) begin
         rx = $signed({2'b00, tgt_row}) + 15'(d - 2);
         if (rx < 0) begin
            rx = -rx;
         end
         if (rx >= hs) begin
            rx = (hs <<< 1) - 15'sd2 - rx;
         end
         lane_s0[d] = rx[LANE_BITS-1:0];
      end
   end

   // stream counters and configuration registers
   always_comb begin
      filter_in  = filter_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lead_in    = lead_ff;
      in_done_in = in_done_ff;
      if (mem_we) begin
         if (in_col_ff == w_m1) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_BITS'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
         if (in_last) begin
            in_done_in = 1'b1;
         end
         if (!emit) begin
            lead_in = lead_ff + LW'(1);
         end
      end
      if (emit) begin
         if (out_last) begin
            // image complete, start the next one
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            lead_in    = '0;
            in_done_in = 1'b0;
         end else if (out_col_ff == w_m1) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_BITS'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
      if (cfg_we) begin
         case (paddr[ADDR_BITS-1:2])
            REG_FILTER_SELECT: begin
               filter_in = pwdata[4:0];
            end
            REG_IMAGE_WIDTH: begin
               width_in   = pwdata[7:0];
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               lead_in    = '0;
               in_done_in = 1'b0;
            end
            REG_IMAGE_HEIGHT: begin
               height_in  = pwdata[HEIGHT_BITS-1:0];
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               lead_in    = '0;
               in_done_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign pop       = rsp_valid & rsp_ready;
   assign credit_in = credit_ff + CRED_BITS'(emit) - CRED_BITS'(pop);

   always_comb begin
      s1_ctrl_in.step     = step_s0;
      s1_ctrl_in.pf_sel   = pf_sel_s0;
      s1_ctrl_in.last     = out_last;
      // a pixel written this cycle in the column being read is taken from the request
      s1_ctrl_in.fwd_hit  = mem_we && (in_col_ff == rd_col);
      s1_ctrl_in.fwd_lane = wr_lane;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff  <= RST_FILTER_SELECT;
         width_ff   <= RST_IMAGE_WIDTH;
         height_ff  <= RST_IMAGE_HEIGHT;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lead_ff    <= '0;
         in_done_ff <= 1'b0;
         credit_ff  <= '0;
         s1_ctrl_ff <= '{step: STEP_NONE, default: '0};
      end else begin
         filter_ff  <= filter_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lead_ff    <= lead_in;
         in_done_ff <= in_done_in;
         credit_ff  <= credit_in;
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   // line store, read-first, one byte lane written per pixel
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_ff[in_col_ff][wr_lane] <= req_data.pixel_value;
      end
      rd_data_ff <= line_store_ff[rd_col];
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= req_data.pixel_value;
      s1_lane_ff  <= lane_s0;
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      for (int l = 0; l < RING_ROWS; l++) begin
         if (s1_ctrl_ff.fwd_hit && (s1_ctrl_ff.fwd_lane == LANE_BITS'(l))) begin
            merged[l] = fwd_data_ff;
         end else begin
            merged[l] = rd_data_ff[l];
         end
      end
      for (int i = 0; i < 5; i++) begin
         col_s1[i] = merged[s1_lane_ff[i]];
      end
   end

   // window update: a row opens as columns 2 1 0 1 2, the last two steps of a
   // row mirror columns already in the window
   always_ff @(posedge clock) begin
      case (s1_ctrl_ff.step)
         STEP_START: begin
            for (int i = 0; i < 5; i++) begin
               win_ff[i][0] <= col_s1[i];
               win_ff[i][1] <= pre_ff[1][i];
               win_ff[i][2] <= pre_ff[0][i];
               win_ff[i][3] <= pre_ff[1][i];
               win_ff[i][4] <= col_s1[i];
            end
         end
         STEP_SHIFT: begin
            for (int i = 0; i < 5; i++) begin
               for (int j = 0; j < 4; j++) begin
                  win_ff[i][j] <= win_ff[i][j+1];
               end
               win_ff[i][4] <= col_s1[i];
            end
         end
         STEP_CENTER: begin
            for (int i = 0; i < 5; i++) begin
               for (int j = 0; j < 4; j++) begin
                  win_ff[i][j] <= win_ff[i][j+1];
               end
               win_ff[i][4] <= win_ff[i][3];
               pre_ff[0][i] <= col_s1[i];
            end
         end
         STEP_EDGE: begin
            for (int i = 0; i < 5; i++) begin
               for (int j = 0; j < 4; j++) begin
                  win_ff[i][j] <= win_ff[i][j+1];
               end
               win_ff[i][4] <= win_ff[i][1];
               pre_ff[1][i] <= col_s1[i];
            end
         end
         STEP_PREFETCH: begin
            for (int i = 0; i < 5; i++) begin
               pre_ff[s1_ctrl_ff.pf_sel][i] <= col_s1[i];
            end
         end
         default: begin
         end
      endcase
   end

   assign s2_valid_in = (s1_ctrl_ff.step == STEP_START) || (s1_ctrl_ff.step == STEP_SHIFT) ||
                        (s1_ctrl_ff.step == STEP_CENTER) || (s1_ctrl_ff.step == STEP_EDGE);

   // ---------------------------------------------------------------- stage 2
   assign vec_row = mask_row_vec(filter_ff);
   assign vec_col = mask_col_vec(filter_ff);

   // horizontal pass of the separable mask
   always_comb begin
      logic signed [13:0] acc_r;
      for (int i = 0; i < 5; i++) begin
         acc_r = '0;
         for (int j = 0; j < 5; j++) begin
            acc_r = acc_r + 14'(LAWS_VEC[vec_col][j]) * $signed({6'd0, win_ff[i][j]});
         end
         row_sum[i] = acc_r;
      end
   end

   always_ff @(posedge clock) begin
      rs_ff <= row_sum;
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      total = '0;
      for (int i = 0; i < 5; i++) begin
         total = total + 18'(LAWS_VEC[vec_row][i]) * 18'(rs_ff[i]);
      end
      if (total < 0) begin
         clamped = 8'd0;
      end else if (total > 18'sd255) begin
         clamped = 8'd255;
      end else begin
         clamped = total[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + (PB + 1)'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + (PB + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_last_ff <= s1_ctrl_ff.last;
      s3_last_ff <= s2_last_ff;
      if (s3_valid_ff) begin
         fifo_ff[wr_ptr_ff[PB-1:0]] <= '{filtered_value: clamped, last_of_image: s3_last_ff};
      end
   end

   // ---------------------------------------------------------------- result queue
   assign fifo_count = wr_ptr_ff - rd_ptr_ff;
   assign rsp_valid  = wr_ptr_ff != rd_ptr_ff;
   assign rsp_data   = fifo_ff[rd_ptr_ff[PB-1:0]];

   // ---------------------------------------------------------------- checks
   a_credit_covers_queue: assert property (@(posedge clock) disable iff (reset)
      credit_ff >= CRED_BITS'(fifo_count))
      else $error("queued results exceed credit");

   a_push_follows_accept: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> $past(req_valid && req_ready, 3))
      else $error("result without an accepted word three cycles before");

   a_lead_bounded: assert property (@(posedge clock) disable iff (reset)
      !in_done_ff |-> (lead_ff <= lead_tgt))
      else $error("input ran ahead of the output window");

   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (fifo_count < (PB + 1)'(FIFO_DEPTH)))
      else $error("push into a full result queue");

endmodule
